/* rtl/kct_pkg.sv */
// ----------------------------------------------------------------------------
// kct_pkg
// Shared types and constants for the key count table: request and result
// words, field widths, status codes and the default table size.
// ----------------------------------------------------------------------------
`default_nettype none

package kct_pkg;

  localparam int KEY_W       = 32;
  localparam int CNT_W       = 24;
  localparam int ENTRIES_DEF = 64;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // request kinds
  localparam logic REQ_INC    = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  // result status codes
  localparam logic [1:0] ST_FOUND  = 2'd0;
  localparam logic [1:0] ST_ADDED  = 2'd1;
  localparam logic [1:0] ST_ABSENT = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  typedef struct packed {
    logic                    req_type;
    logic signed [KEY_W-1:0] key;
  } req_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] total;
    logic [1:0]       status;
  } rsp_t;

endpackage

`default_nettype wire

/* rtl/kct_ram.sv */
// ----------------------------------------------------------------------------
// kct_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module kct_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/key_count_table.sv */
// ----------------------------------------------------------------------------
// key_count_table
// Bounded key-to-count table. Increment requests bump or append an entry,
// lookup requests return the count; a saturating running total rides along.
// ----------------------------------------------------------------------------
//
//   channel  direction  word    handshake
//   in_      input      req_t   in_valid / in_stall
//   out_     output     rsp_t   out_valid / out_stall
//
// One request at a time. The key memory is scanned one entry per cycle with
// the count memory read alongside it.
// Reset clears only the occupancy, the total and control; the memories need
// no clearing pass since entries at or above the occupancy are never read.
// A stalled result waits in the output register; a new request is taken
// once the previous result has been handed to that register.
`default_nettype none

module key_count_table #(
  parameter int ENTRIES = kct_pkg::ENTRIES_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire kct_pkg::req_t in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output kct_pkg::rsp_t      out_data
);

  import kct_pkg::*;

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OW = $clog2(ENTRIES + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]       state_r, state_nxt;
  req_t             req_r, req_nxt;
  logic [OW-1:0]    occ_r, occ_nxt;
  logic [OW-1:0]    scan_idx_r, scan_idx_nxt;
  logic             cmp_vld_r, cmp_vld_nxt;
  logic [AW-1:0]    cmp_idx_r, cmp_idx_nxt;
  logic [CNT_W-1:0] total_r, total_nxt;
  rsp_t             res_r, res_nxt;
  logic             out_vld_r, out_vld_nxt;
  rsp_t             out_data_r, out_data_nxt;

  logic             key_we, cnt_we;
  logic [AW-1:0]    key_waddr, cnt_waddr;
  logic [CNT_W-1:0] cnt_wdata;
  logic [KEY_W-1:0] key_rdata;
  logic [CNT_W-1:0] cnt_rdata;

  logic             in_acc, can_load, issue, hit, miss;
  logic [CNT_W-1:0] total_inc;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;
  assign can_load  = !out_vld_r || !out_stall;

  assign issue     = (state_r == S_SCAN) && (scan_idx_r < occ_r);
  assign hit       = cmp_vld_r && (key_rdata == $unsigned(req_r.key));
  assign miss      = !issue && !hit;
  assign total_inc = (total_r == CNT_MAX) ? CNT_MAX : total_r + 1'b1;

  // key and count memories, read at the scan address together
  kct_ram #(.WIDTH(KEY_W), .DEPTH(ENTRIES)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata ($unsigned(req_r.key)),
    .raddr (scan_idx_r[AW-1:0]),
    .rdata (key_rdata)
  );

  kct_ram #(.WIDTH(CNT_W), .DEPTH(ENTRIES)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (scan_idx_r[AW-1:0]),
    .rdata (cnt_rdata)
  );

  // sequence: accept, scan, decide and write back, hand off result
  always_comb begin
    state_nxt    = state_r;
    req_nxt      = req_r;
    occ_nxt      = occ_r;
    scan_idx_nxt = scan_idx_r;
    cmp_vld_nxt  = 1'b0;
    cmp_idx_nxt  = cmp_idx_r;
    total_nxt    = total_r;
    res_nxt      = res_r;
    out_vld_nxt  = out_vld_r && out_stall;
    out_data_nxt = out_data_r;
    key_we       = 1'b0;
    cnt_we       = 1'b0;
    key_waddr    = occ_r[AW-1:0];
    cnt_waddr    = cmp_idx_r;
    cnt_wdata    = cnt_rdata + 1'b1;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          req_nxt      = in_data;
          scan_idx_nxt = '0;
          state_nxt    = S_SCAN;
        end
      end

      S_SCAN: begin
        // advance the read address while entries remain
        cmp_vld_nxt  = issue;
        cmp_idx_nxt  = scan_idx_r[AW-1:0];
        scan_idx_nxt = scan_idx_r + OW'(issue);
        if (hit) begin
          state_nxt = S_DONE;
          if (req_r.req_type == REQ_LOOKUP) begin
            res_nxt = '{count: cnt_rdata, total: total_r, status: ST_FOUND};
          end else if (cnt_rdata != CNT_MAX) begin
            cnt_we    = 1'b1;
            total_nxt = total_inc;
            res_nxt   = '{count: cnt_wdata, total: total_inc, status: ST_FOUND};
          end else begin
            res_nxt = '{count: cnt_rdata, total: total_r, status: ST_FOUND};
          end
        end else if (miss) begin
          state_nxt = S_DONE;
          if (req_r.req_type == REQ_LOOKUP) begin
            res_nxt = '{count: '0, total: total_r, status: ST_ABSENT};
          end else if (occ_r < OW'(ENTRIES)) begin
            // append the key with a count of one
            key_we    = 1'b1;
            cnt_we    = 1'b1;
            cnt_waddr = occ_r[AW-1:0];
            cnt_wdata = CNT_W'(1);
            occ_nxt   = occ_r + 1'b1;
            total_nxt = total_inc;
            res_nxt   = '{count: CNT_W'(1), total: total_inc, status: ST_ADDED};
          end else begin
            res_nxt = '{count: '0, total: total_r, status: ST_FULL};
          end
        end
      end

      S_DONE: begin
        if (can_load) begin
          out_vld_nxt  = 1'b1;
          out_data_nxt = res_r;
          state_nxt    = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      occ_r     <= '0;
      total_r   <= '0;
      cmp_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      occ_r     <= occ_nxt;
      total_r   <= total_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    scan_idx_r <= scan_idx_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  // checks
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OW'(ENTRIES))
    else $error("occupancy beyond table size");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (scan_idx_r <= occ_r))
    else $error("scan index past occupancy");

  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && res_r.status == ST_FULL) |-> (occ_r == OW'(ENTRIES)))
    else $error("drop flagged while table has room");

  a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_SCAN))
    else $error("accepted word did not start a scan");

endmodule

`default_nettype wire

/* verif/kct_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// kct_checker
// Passive scoreboard for the key count table. It keeps its own copy of the
// key/count table and the running total. For every request word taken on
// the in_ channel it predicts the result word, and it compares each result
// word taken on the out_ channel against the oldest prediction.
// ----------------------------------------------------------------------------

module kct_checker #(
  parameter int ENTRIES = kct_pkg::ENTRIES_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_stall,
  input  kct_pkg::req_t in_data,
  input  logic          out_valid,
  input  logic          out_stall,
  input  kct_pkg::rsp_t out_data,
  output int            fail_count,
  output int            outstanding
);
  import kct_pkg::*;

  // table image: slots below slots_used hold live entries
  logic [KEY_W-1:0] key_tab [ENTRIES];
  logic [CNT_W-1:0] cnt_tab [ENTRIES];
  int               slots_used = 0;
  logic [CNT_W-1:0] total_sum  = '0;

  // predicted result words, oldest first
  rsp_t pending_rsp [$];
  int   errs      = 0;
  int   rsp_index = 0;

  // Apply one request word to the table image and return the result word.
  // Count and total saturation take about 2^24 increments, so a regression
  // of practical length does not reach them; they are modeled all the same.
  function automatic rsp_t count_request(input req_t w);
    rsp_t r;
    int   slot;
    slot     = -1;
    r.count  = '0;
    r.status = ST_ABSENT;
    for (int i = 0; i < slots_used; i++) begin
      if (slot < 0 && key_tab[i] == w.key) slot = i;
    end
    if (w.req_type == REQ_LOOKUP) begin
      if (slot >= 0) begin
        r.count  = cnt_tab[slot];
        r.status = ST_FOUND;
      end
    end else if (slot >= 0) begin
      // a count at its ceiling stays put and leaves the total alone
      if (cnt_tab[slot] != CNT_MAX) begin
        cnt_tab[slot] = cnt_tab[slot] + 1'b1;
        if (total_sum != CNT_MAX) total_sum = total_sum + 1'b1;
      end
      r.count  = cnt_tab[slot];
      r.status = ST_FOUND;
    end else if (slots_used < ENTRIES) begin
      key_tab[slots_used] = w.key;
      cnt_tab[slots_used] = CNT_W'(1);
      slots_used++;
      if (total_sum != CNT_MAX) total_sum = total_sum + 1'b1;
      r.count  = CNT_W'(1);
      r.status = ST_ADDED;
    end else begin
      r.status = ST_FULL;
    end
    r.total = total_sum;
    return r;
  endfunction

  // Compare results first: a result taken at this edge always belongs to an
  // earlier request word than one taken at the same edge.
  always @(posedge clk) begin
    rsp_t want;
    if (!rst_n) begin
      slots_used = 0;
      total_sum  = '0;
      pending_rsp.delete();
    end else begin
      if (out_valid && !out_stall) begin
        rsp_index++;
        if (pending_rsp.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("%0t: result %0d with no request outstanding: %0d/%0d/%0d",
                     $realtime, rsp_index, out_data.count, out_data.total,
                     out_data.status);
        end else begin
          want = pending_rsp.pop_front();
          if (out_data.count !== want.count || out_data.total !== want.total ||
              out_data.status !== want.status) begin
            errs++;
            if (errs <= 10)
              $display("%0t: result %0d count/total/status exp %0d/%0d/%0d got %0d/%0d/%0d",
                       $realtime, rsp_index, want.count, want.total, want.status,
                       out_data.count, out_data.total, out_data.status);
          end
        end
      end
      if (in_valid && !in_stall) pending_rsp.push_back(count_request(in_data));
    end
    fail_count  <= errs;
    outstanding <= pending_rsp.size();
  end

endmodule

/* verif/tb_key_count_table.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_key_count_table
// Stimulus and verdict for the key count table. A directed opening covers
// the key extremes, both request kinds, absent-key lookups and keys one bit
// apart; a random run then draws keys mostly from a reused pool so that the
// table fills up and hits land on every slot, after which new keys are
// dropped as table-full. The sender works in bursts, the receiver stalls on
// its own pattern, and a separate checker predicts and compares results.
// ----------------------------------------------------------------------------

module tb_key_count_table;
  import kct_pkg::*;

  localparam int CLK_PERIOD   = 8;
  localparam int ENTRIES      = ENTRIES_DEF;
  localparam int RANDOM_WORDS = 750;
  localparam int POOL_SIZE    = 80;
  localparam int DRAIN_CYCLES = ENTRIES + 16;
  localparam int TIMEOUT_NS   = 16_000_000;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_HOLD} stall_mode_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  req_t in_data;
  logic out_valid;
  logic out_stall;
  rsp_t out_data;
  int   fail_count;
  int   outstanding;

  int               burst_left;
  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  key_count_table #(
    .ENTRIES (ENTRIES)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  kct_checker #(
    .ENTRIES (ENTRIES)
  ) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // free-running clock
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // hard stop for a hung run
  initial begin
    #(TIMEOUT_NS);
    $display("Regression FAIL");
    $finish;
  end

  // receiver: switch between stall modes for random stretches
  initial begin
    stall_mode_t mode;
    int          run_len;
    out_stall = 1'b0;
    forever begin
      mode    = stall_mode_t'($urandom_range(3));
      run_len = $urandom_range(60, 5);
      repeat (run_len) begin
        @(negedge clk);
        case (mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(99) < 30);
          STALL_HEAVY: out_stall <= ($urandom_range(99) < 75);
          default:     out_stall <= 1'b1;
        endcase
      end
    end
  end

  // Drive one request word and hold it until taken. Between bursts, drop
  // valid for a random gap.
  task automatic send_word(input logic kind, input logic [KEY_W-1:0] k);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(40, 1);
      gap        = ($urandom_range(3) == 0) ? 0 : $urandom_range(24);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    in_data  <= '{req_type: kind, key: k};
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Hold off the sender until every predicted result has come back.
  task automatic wait_quiet();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    logic             kind;
    logic [KEY_W-1:0] k;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    burst_left = 0;

    // key pool: extremes, random keys, and near neighbors one bit apart
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    key_pool[2] = 32'h8000_0000;
    key_pool[3] = 32'h7FFF_FFFF;
    for (int i = 4; i < POOL_SIZE; i++) begin
      if (i % 5 == 0)
        key_pool[i] = key_pool[$urandom_range(i - 1)] ^ (32'd1 << $urandom_range(KEY_W - 1));
      else
        key_pool[i] = $urandom();
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed opening: empty-table lookup, extremes, hits, absent keys
    send_word(REQ_LOOKUP, 32'h0000_0000);
    send_word(REQ_INC,    32'h0000_0000);
    send_word(REQ_INC,    32'h0000_0000);
    send_word(REQ_LOOKUP, 32'h0000_0000);
    send_word(REQ_INC,    32'h8000_0000);
    send_word(REQ_INC,    32'h7FFF_FFFF);
    send_word(REQ_INC,    32'hFFFF_FFFF);
    send_word(REQ_INC,    32'h0000_0001);
    send_word(REQ_LOOKUP, 32'hFFFF_FFFE);
    send_word(REQ_LOOKUP, 32'h7FFF_FFFF);
    send_word(REQ_INC,    32'h8000_0000);
    send_word(REQ_LOOKUP, 32'h8000_0001);
    send_word(REQ_INC,    32'hFFFF_FFFF);
    send_word(REQ_LOOKUP, 32'hFFFF_FFFF);
    send_word(REQ_LOOKUP, 32'h0000_0001);

    // random run: mostly pooled keys so the table fills and then overflows
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i == RANDOM_WORDS / 2) wait_quiet();
      kind = ($urandom_range(99) < 60) ? REQ_INC : REQ_LOOKUP;
      k    = ($urandom_range(99) < 80) ? key_pool[$urandom_range(POOL_SIZE - 1)]
                                       : $urandom();
      send_word(kind, k);
    end

    // drain, then let any stray result show up
    wait_quiet();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
